FILE: rtl/awt_pkg.sv
// Shared types and constants for the bounding box world transform block.
`default_nettype none

package awt_pkg;

  // Field and register widths.
  localparam int COORD_W = 32;
  localparam int COEF_W = 32;
  localparam int CFG_W = 2 * COEF_W;
  localparam int PROD_W = COORD_W + COEF_W;
  localparam int SUM_W = PROD_W + 2;
  localparam int NUM_PAIRS = 6;
  localparam int NUM_AXES = 3;
  localparam int NUM_ROWS = 4;
  localparam int FRAC_BITS_DEF = 16;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic [CFG_W-1:0] cfg_word_t;

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    CFG_COEF_PAIR_0 = 3'd0,
    CFG_COEF_PAIR_1 = 3'd1,
    CFG_COEF_PAIR_2 = 3'd2,
    CFG_COEF_PAIR_3 = 3'd3,
    CFG_COEF_PAIR_4 = 3'd4,
    CFG_COEF_PAIR_5 = 3'd5
  } cfg_idx_t;

endpackage

`default_nettype wire

FILE: rtl/aabb_world_transform.sv
// Top level: world-space bounding box of a local box under an affine matrix.
// An accepted input word passes through the stage 0 to 3 registers and then the output register.
// One box is accepted per cycle unless the output stalls; the product stage holds eighteen 32x32
// multipliers, one for each linear coefficient and box bound, so no unit is shared.
// Reset clears every pipeline valid bit and loads the identity matrix.
// Payload registers are not reset.
`default_nettype none

module aabb_world_transform #(
  parameter int FRAC_BITS = awt_pkg::FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Configuration write port
  input  wire logic                  cfg_we,
  input  wire logic [2:0]            cfg_index,
  input  wire awt_pkg::cfg_word_t    cfg_wdata,
  // Input channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire awt_pkg::coord_t       in_local_min_x,
  input  wire awt_pkg::coord_t       in_local_min_y,
  input  wire awt_pkg::coord_t       in_local_min_z,
  input  wire awt_pkg::coord_t       in_local_max_x,
  input  wire awt_pkg::coord_t       in_local_max_y,
  input  wire awt_pkg::coord_t       in_local_max_z,
  // Result channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output awt_pkg::coord_t            out_world_min_x,
  output awt_pkg::coord_t            out_world_min_y,
  output awt_pkg::coord_t            out_world_min_z,
  output awt_pkg::coord_t            out_world_max_x,
  output awt_pkg::coord_t            out_world_max_y,
  output awt_pkg::coord_t            out_world_max_z
);

  localparam int NA = awt_pkg::NUM_AXES;
  localparam int NR = awt_pkg::NUM_ROWS;
  localparam int CW = awt_pkg::COEF_W;
  localparam awt_pkg::cfg_word_t UNIT_PAIR = awt_pkg::CFG_W'(1) << FRAC_BITS;
  localparam awt_pkg::sum_t HALF_LSB = awt_pkg::SUM_W'(1) << (FRAC_BITS - 1);
  localparam awt_pkg::sum_t SAT_MAX = awt_pkg::SUM_W'(32'sh7FFF_FFFF);
  localparam awt_pkg::sum_t SAT_MIN = ~SAT_MAX;

  // Configuration registers and the coefficient view of them.
  awt_pkg::cfg_word_t coef_pair_r [awt_pkg::NUM_PAIRS];
  awt_pkg::coef_t     coef_m [NR][NA];

  // Pipeline registers.
  logic               s0_vld_r, s1_vld_r, s2_vld_r, s3_vld_r, out_vld_r;
  awt_pkg::coord_t    s0_lo_r [NA];
  awt_pkg::coord_t    s0_hi_r [NA];
  awt_pkg::prod_t     s1_plo_r [NA][NA];
  awt_pkg::prod_t     s1_phi_r [NA][NA];
  awt_pkg::prod_t     s1_plo_nxt [NA][NA];
  awt_pkg::prod_t     s1_phi_nxt [NA][NA];
  awt_pkg::prod_t     s2_tmin_r [NA][NA];
  awt_pkg::prod_t     s2_tmax_r [NA][NA];
  awt_pkg::sum_t      s3_amin_r [NA];
  awt_pkg::sum_t      s3_bmin_r [NA];
  awt_pkg::sum_t      s3_amax_r [NA];
  awt_pkg::sum_t      s3_bmax_r [NA];
  awt_pkg::coord_t    out_min_r [NA];
  awt_pkg::coord_t    out_max_r [NA];
  awt_pkg::coord_t    out_min_nxt [NA];
  awt_pkg::coord_t    out_max_nxt [NA];

  // Each stage loads when it is empty or the stage after it moves on.
  logic rdy0, rdy1, rdy2, rdy3, rdy_out;

  assign rdy_out = !out_vld_r || !out_stall;
  assign rdy3 = !s3_vld_r || rdy_out;
  assign rdy2 = !s2_vld_r || rdy3;
  assign rdy1 = !s1_vld_r || rdy2;
  assign rdy0 = !s0_vld_r || rdy1;
  assign in_stall = !rdy0;

  // Configuration writes; unknown indexes are ignored.
  // Even pairs hold a diagonal coefficient in their low half at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < awt_pkg::NUM_PAIRS; p++) begin
        coef_pair_r[p] <= p[0] ? '0 : UNIT_PAIR;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        awt_pkg::CFG_COEF_PAIR_0: coef_pair_r[0] <= cfg_wdata;
        awt_pkg::CFG_COEF_PAIR_1: coef_pair_r[1] <= cfg_wdata;
        awt_pkg::CFG_COEF_PAIR_2: coef_pair_r[2] <= cfg_wdata;
        awt_pkg::CFG_COEF_PAIR_3: coef_pair_r[3] <= cfg_wdata;
        awt_pkg::CFG_COEF_PAIR_4: coef_pair_r[4] <= cfg_wdata;
        awt_pkg::CFG_COEF_PAIR_5: coef_pair_r[5] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Coefficients are packed two to a register in row-major order, low half first.
  always_comb begin
    for (int r = 0; r < NR; r++) begin
      for (int c = 0; c < NA; c++) begin
        coef_m[r][c] = coef_pair_r[(r * NA + c) >> 1][((r * NA + c) & 1) * CW +: CW];
      end
    end
  end

  // Valid bits of the pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (rdy0) s0_vld_r <= in_valid;
      if (rdy1) s1_vld_r <= s0_vld_r;
      if (rdy2) s2_vld_r <= s1_vld_r;
      if (rdy3) s3_vld_r <= s2_vld_r;
      if (rdy_out) out_vld_r <= s3_vld_r;
    end
  end

  // Stage 0: capture the box bounds.
  always_ff @(posedge clk) begin
    if (rdy0) begin
      s0_lo_r[0] <= in_local_min_x;
      s0_lo_r[1] <= in_local_min_y;
      s0_lo_r[2] <= in_local_min_z;
      s0_hi_r[0] <= in_local_max_x;
      s0_hi_r[1] <= in_local_max_y;
      s0_hi_r[2] <= in_local_max_z;
    end
  end

  // Stage 1: each bound times each linear coefficient, one multiplier apiece.
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NA; j++) begin
        s1_plo_nxt[i][j] = s0_lo_r[i] * coef_m[i][j];
        s1_phi_nxt[i][j] = s0_hi_r[i] * coef_m[i][j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_plo_r <= s1_plo_nxt;
      s1_phi_r <= s1_phi_nxt;
    end
  end

  // Stage 2: the extreme corners of an affine map pick, per term, the smaller
  // or larger of the two products. Rounding and saturation are monotonic, so
  // the per-axis extremes follow from these term extremes exactly.
  always_ff @(posedge clk) begin
    if (rdy2) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NA; j++) begin
          if (s1_plo_r[i][j] < s1_phi_r[i][j]) begin
            s2_tmin_r[i][j] <= s1_plo_r[i][j];
            s2_tmax_r[i][j] <= s1_phi_r[i][j];
          end else begin
            s2_tmin_r[i][j] <= s1_phi_r[i][j];
            s2_tmax_r[i][j] <= s1_plo_r[i][j];
          end
        end
      end
    end
  end

  // Stage 3: partial sums; translation and the rounding half join the z term.
  always_ff @(posedge clk) begin
    if (rdy3) begin
      for (int j = 0; j < NA; j++) begin
        s3_amin_r[j] <= awt_pkg::SUM_W'(s2_tmin_r[0][j]) + awt_pkg::SUM_W'(s2_tmin_r[1][j]);
        s3_amax_r[j] <= awt_pkg::SUM_W'(s2_tmax_r[0][j]) + awt_pkg::SUM_W'(s2_tmax_r[1][j]);
        s3_bmin_r[j] <= awt_pkg::SUM_W'(s2_tmin_r[2][j])
                      + (awt_pkg::SUM_W'(coef_m[NR-1][j]) <<< FRAC_BITS) + HALF_LSB;
        s3_bmax_r[j] <= awt_pkg::SUM_W'(s2_tmax_r[2][j])
                      + (awt_pkg::SUM_W'(coef_m[NR-1][j]) <<< FRAC_BITS) + HALF_LSB;
      end
    end
  end

  // Stage 4: final add, drop the fraction bits with a floor, and saturate.
  always_comb begin
    awt_pkg::sum_t qmin;
    awt_pkg::sum_t qmax;
    for (int j = 0; j < NA; j++) begin
      qmin = (s3_amin_r[j] + s3_bmin_r[j]) >>> FRAC_BITS;
      qmax = (s3_amax_r[j] + s3_bmax_r[j]) >>> FRAC_BITS;
      if (qmin > SAT_MAX) begin
        out_min_nxt[j] = awt_pkg::COORD_W'(SAT_MAX);
      end else if (qmin < SAT_MIN) begin
        out_min_nxt[j] = awt_pkg::COORD_W'(SAT_MIN);
      end else begin
        out_min_nxt[j] = awt_pkg::COORD_W'(qmin);
      end
      if (qmax > SAT_MAX) begin
        out_max_nxt[j] = awt_pkg::COORD_W'(SAT_MAX);
      end else if (qmax < SAT_MIN) begin
        out_max_nxt[j] = awt_pkg::COORD_W'(SAT_MIN);
      end else begin
        out_max_nxt[j] = awt_pkg::COORD_W'(qmax);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      out_min_r <= out_min_nxt;
      out_max_r <= out_max_nxt;
    end
  end

  // Result word outputs.
  assign out_valid = out_vld_r;
  assign out_world_min_x = out_min_r[0];
  assign out_world_min_y = out_min_r[1];
  assign out_world_min_z = out_min_r[2];
  assign out_world_max_x = out_max_r[0];
  assign out_world_max_y = out_max_r[1];
  assign out_world_max_z = out_max_r[2];

`ifndef ASSERT_OFF
  // The input side only stalls when every stage holds a word and the output is held.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s0_vld_r && s1_vld_r && s2_vld_r && s3_vld_r && out_vld_r && out_stall))
    else $error("input stalled while the pipeline has room");

  // A word in the last stage moves to the output when the output can take it.
  a_last_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_vld_r && rdy_out) |=> out_vld_r)
    else $error("word lost between the sum stage and the output register");

  // The reported minimum never exceeds the reported maximum on any axis.
  a_min_not_above_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_world_min_x <= out_world_max_x &&
                   out_world_min_y <= out_world_max_y &&
                   out_world_min_z <= out_world_max_z))
    else $error("world minimum above world maximum");
`endif

endmodule

`default_nettype wire
